>>> rtl/core/box_mean_3x3_clipped_macros.svh
// assertion macros for the 3x3 clipped box mean block
// no dependencies; included by the modules that carry assertions
`ifndef BOX_MEAN_3X3_CLIPPED_MACROS_SVH
`define BOX_MEAN_3X3_CLIPPED_MACROS_SVH
`ifndef SYNTH
`define BMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/bmc_pkg.sv
// shared types and constants of the 3x3 clipped box mean block
// no dependencies; used by every module of the block
`default_nettype none

package bmc_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_PIXEL_BITS = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int MODE_W     = 2;
	localparam int ROW_W      = 13;
	localparam int MAX_HEIGHT = 4096;
	localparam int FW_RESET   = 640;
	localparam int FH_RESET   = 480;
	localparam int NBR        = 9;
	localparam int CNT_W      = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd2;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALL  = 2'd0,
		MODE_EVEN = 2'd1,
		MODE_ODD  = 2'd2
	} mode_t;

	typedef struct packed {
		logic           have;
		logic           fe;
		logic [NBR-1:0] mask;
	} ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/bmc_line_mem.sv
// dual line store: one write and one registered read per cycle
// uses bmc_pkg for default sizes
`default_nettype none

module bmc_line_mem #(
	parameter int DEPTH  = bmc_pkg::DEF_MAX_WIDTH,
	parameter int DATA_W = 2 * bmc_pkg::DEF_PIXEL_BITS,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/bmc_ctrl.sv
// configuration registers, raster position tracking and border masks
// uses bmc_pkg; feeds the line store read port and the window stage
`default_nettype none

module bmc_ctrl #(
	parameter int MAX_WIDTH  = bmc_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = bmc_pkg::DEF_PIXEL_BITS,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bmc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [bmc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [PIXEL_BITS-1:0]            pixel,
	input  logic                             flush,
	input  logic                             adv,
	output logic                             act,
	output logic [COL_W-1:0]                 addr,
	output logic [PIXEL_BITS-1:0]            pix,
	output bmc_pkg::ctl_t                    ctl,
	output bmc_pkg::mode_t                   mode
);

	import bmc_pkg::*;

	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W  = WID_W + 1;
	localparam int RC_W   = ROW_W + 1;
	localparam int AREA_W = WID_W + ROW_W;
	localparam int OC_W   = AREA_W + 1;
	localparam int W_RST  = (FW_RESET > MAX_WIDTH) ? MAX_WIDTH : FW_RESET;
	localparam logic [WID_W-1:0]  W_EFF_RST = WID_W'(W_RST);
	localparam logic [ROW_W-1:0]  H_EFF_RST = ROW_W'(FH_RESET);
	localparam logic [AREA_W-1:0] AREA_RST  = AREA_W'(W_RST * FH_RESET);

	function automatic mode_t mode_decode(input logic [MODE_W-1:0] code);
		mode_t m;
		m = MODE_ALL;
		if (code == MODE_EVEN) begin
			m = MODE_EVEN;
		end else if (code == MODE_ODD) begin
			m = MODE_ODD;
		end
		return m;
	endfunction

	logic [FW_W-1:0]   fw_q;
	logic [FH_W-1:0]   fh_q;
	mode_t             mode_q;
	logic              cfg_busy_q;
	logic [WID_W-1:0]  w_eff_q;
	logic [ROW_W-1:0]  h_eff_q;
	logic [AREA_W-1:0] area_q;
	logic [COL_W-1:0]  x_q;
	logic [ROW_W-1:0]  row_q;
	logic [AREA_W-1:0] out_q;

	logic [WID_W-1:0]  w_clamp;
	logic [ROW_W-1:0]  h_clamp;
	logic              draining;
	logic              skip;
	logic              row_end;
	logic              col_out;
	logic              have;
	logic              area_hit;
	logic              row_wrap;
	logic [CMP_W-1:0]  xc;
	logic [CMP_W-1:0]  wc;
	logic [ROW_W-1:0]  crow;
	logic [RC_W-1:0]   crowc;
	logic [RC_W-1:0]   hc;
	logic [OC_W-1:0]   out_n;
	logic [2:0]        rowv;
	logic [2:0]        colv;
	logic [NBR-1:0]    mask;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= FW_W'(FW_RESET);
			fh_q       <= FH_W'(FH_RESET);
			mode_q     <= MODE_ALL;
			cfg_busy_q <= 1'b0;
		end else begin
			cfg_busy_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_FRAME_WIDTH:  fw_q <= cfg_wdata[FW_W-1:0];
					CFG_FRAME_HEIGHT: fh_q <= cfg_wdata[FH_W-1:0];
					CFG_FILTER_MODE:  mode_q <= mode_decode(cfg_wdata[MODE_W-1:0]);
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		w_clamp = WID_W'(fw_q);
		if (fw_q == '0) begin
			w_clamp = WID_W'(1);
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			w_clamp = WID_W'(MAX_WIDTH);
		end
		h_clamp = ROW_W'(fh_q);
		if (fh_q == '0) begin
			h_clamp = ROW_W'(1);
		end else if (32'(fh_q) > 32'(MAX_HEIGHT)) begin
			h_clamp = ROW_W'(MAX_HEIGHT);
		end
	end

	// clamped frame size and pixel count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q <= W_EFF_RST;
			h_eff_q <= H_EFF_RST;
			area_q  <= AREA_RST;
		end else begin
			w_eff_q <= w_clamp;
			h_eff_q <= h_clamp;
			area_q  <= AREA_W'(w_clamp) * AREA_W'(h_clamp);
		end
	end

	always_comb begin
		xc       = CMP_W'(x_q);
		wc       = CMP_W'(w_eff_q);
		hc       = RC_W'(h_eff_q);
		draining = row_q >= h_eff_q;
		skip     = flush && !draining;
		in_ready = adv && !cfg_busy_q;
		act      = in_valid && in_ready && !skip;
		row_end  = (x_q == '0) && (row_q >= ROW_W'(2));
		col_out  = (x_q != '0) && (row_q != '0);
		have     = row_end || col_out;
		crow     = col_out ? row_q - ROW_W'(1) : row_q - ROW_W'(2);
		crowc    = RC_W'(crow);
		out_n    = OC_W'(out_q) + OC_W'(1);
		area_hit = out_n >= OC_W'(area_q);
		row_wrap = (xc + CMP_W'(1)) >= wc;

		rowv[0] = (crow != '0) && (crowc - RC_W'(1) < hc);
		rowv[1] = crowc < hc;
		rowv[2] = crowc + RC_W'(1) < hc;
		colv[0] = row_end ? (wc >= CMP_W'(2))
		                  : ((xc >= CMP_W'(2)) && (xc - CMP_W'(2) < wc));
		colv[1] = row_end ? 1'b1 : (xc - CMP_W'(1) < wc);
		colv[2] = row_end ? 1'b0 : (xc < wc);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mask[r * 3 + c] = rowv[r] && colv[c];
			end
		end
	end

	// raster position and output count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			row_q <= '0;
			out_q <= '0;
		end else if (act) begin
			if (have && area_hit) begin
				x_q   <= '0;
				row_q <= '0;
				out_q <= '0;
			end else begin
				if (row_wrap) begin
					x_q   <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					x_q <= x_q + COL_W'(1);
				end
				if (have) begin
					out_q <= out_q + AREA_W'(1);
				end
			end
		end
	end

	assign addr     = x_q;
	assign pix      = draining ? '0 : pixel;
	assign ctl.have = have;
	assign ctl.fe   = have && area_hit;
	assign ctl.mask = mask;
	assign mode     = mode_q;

endmodule

`default_nettype wire

>>> rtl/core/bmc_window.sv
// line store read-modify-write, 3x3 window and masked neighbor sum
// uses bmc_pkg and the assertion macros; drives bmc_line_mem
`default_nettype none

`include "box_mean_3x3_clipped_macros.svh"

module bmc_window #(
	parameter int MAX_WIDTH  = bmc_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = bmc_pkg::DEF_PIXEL_BITS,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int SUM_W = PIXEL_BITS + bmc_pkg::CNT_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      act,
	input  logic [COL_W-1:0]          addr,
	input  logic [PIXEL_BITS-1:0]     pix,
	input  bmc_pkg::ctl_t             ctl,
	input  bmc_pkg::mode_t            mode,
	input  logic [2*PIXEL_BITS-1:0]   mem_rdata,
	output logic                      mem_we,
	output logic [COL_W-1:0]          mem_waddr,
	output logic [2*PIXEL_BITS-1:0]   mem_wdata,
	output logic                      out_valid,
	output logic [SUM_W-1:0]          out_sum,
	output logic [bmc_pkg::CNT_W-1:0] out_cnt,
	output logic                      out_fe
);

	import bmc_pkg::*;

	function automatic logic picked(input mode_t m, input logic lsb);
		logic p;
		unique case (m)
			MODE_EVEN: p = !lsb;
			MODE_ODD:  p = lsb;
			MODE_ALL:  p = 1'b1;
			default:   p = 1'b1;
		endcase
		return p;
	endfunction

	logic                    valid_s1;
	logic                    fwd_s1;
	logic [COL_W-1:0]        addr_s1;
	logic [PIXEL_BITS-1:0]   pix_s1;
	ctl_t                    ctl_s1;
	logic [2*PIXEL_BITS-1:0] fwd_data_s1;

	logic                    valid_s2;
	logic [SUM_W-1:0]        sum_s2;
	logic [CNT_W-1:0]        cnt_s2;
	logic                    fe_s2;

	logic [PIXEL_BITS-1:0]   win_b_q [3];
	logic [PIXEL_BITS-1:0]   win_c_q [3];

	logic [2*PIXEL_BITS-1:0] col_d;
	logic [PIXEL_BITS-1:0]   up_d;
	logic [PIXEL_BITS-1:0]   mid_d;
	logic [PIXEL_BITS-1:0]   nbr [NBR];
	logic [SUM_W-1:0]        sum_d;
	logic [CNT_W-1:0]        cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (adv) begin
			valid_s1 <= act;
			fwd_s1   <= act && valid_s1 && (addr == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1     <= addr;
			pix_s1      <= pix;
			ctl_s1      <= ctl;
			fwd_data_s1 <= mem_wdata;
		end
	end

	// bypass when the previous item wrote the same column in the read cycle
	always_comb begin
		col_d  = fwd_s1 ? fwd_data_s1 : mem_rdata;
		up_d   = col_d[2*PIXEL_BITS-1:PIXEL_BITS];
		mid_d  = col_d[PIXEL_BITS-1:0];
		nbr[0] = win_b_q[0];
		nbr[1] = win_c_q[0];
		nbr[2] = up_d;
		nbr[3] = win_b_q[1];
		nbr[4] = win_c_q[1];
		nbr[5] = mid_d;
		nbr[6] = win_b_q[2];
		nbr[7] = win_c_q[2];
		nbr[8] = pix_s1;
		sum_d  = '0;
		cnt_d  = '0;
		for (int i = 0; i < NBR; i++) begin
			if (ctl_s1.mask[i] && picked(mode, nbr[i][0])) begin
				sum_d = sum_d + SUM_W'(nbr[i]);
				cnt_d = cnt_d + CNT_W'(1);
			end
		end
	end

	assign mem_we    = valid_s1 && adv;
	assign mem_waddr = addr_s1;
	assign mem_wdata = {mid_d, pix_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				win_b_q[r] <= '0;
				win_c_q[r] <= '0;
			end
		end else if (adv && valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_b_q[r] <= win_c_q[r];
			end
			win_c_q[0] <= up_d;
			win_c_q[1] <= mid_d;
			win_c_q[2] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && ctl_s1.have;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sum_d;
			cnt_s2 <= cnt_d;
			fe_s2  <= ctl_s1.fe;
		end
	end

	assign out_valid = valid_s2;
	assign out_sum   = sum_s2;
	assign out_cnt   = cnt_s2;
	assign out_fe    = fe_s2;

	`BMC_ASSERT_IMP(a_fwd_needs_item, clk, arst_n, fwd_s1, valid_s1, "bypass without item")
	`BMC_ASSERT_IMP(a_empty_sum_zero, clk, arst_n, valid_s2 && (cnt_s2 == '0), sum_s2 == '0, "sum without neighbors")
	`BMC_ASSERT_IMP(a_cnt_bound, clk, arst_n, valid_s2, cnt_s2 <= CNT_W'(NBR), "neighbor count too high")

endmodule

`default_nettype wire

>>> rtl/core/bmc_div.sv
// division of the neighbor sum by the count through a reciprocal table
// uses bmc_pkg; holds the output register of the block
`default_nettype none

module bmc_div #(
	parameter int PIXEL_BITS = bmc_pkg::DEF_PIXEL_BITS,
	localparam int SUM_W = PIXEL_BITS + bmc_pkg::CNT_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic [SUM_W-1:0]          sum,
	input  logic [bmc_pkg::CNT_W-1:0] cnt,
	input  logic                      fe,
	output logic                      out_valid,
	output logic [PIXEL_BITS-1:0]     mean,
	output logic                      last
);

	import bmc_pkg::*;

	// floor(2^K / n) + 1 gives the exact truncated quotient for sums below 9 * 2^PIXEL_BITS
	localparam int K      = PIXEL_BITS + 7;
	localparam int RW     = K + 1;
	localparam int PROD_W = SUM_W + RW;
	localparam logic [RW-1:0] R1 = RW'((2 ** K) / 1 + 1);
	localparam logic [RW-1:0] R2 = RW'((2 ** K) / 2 + 1);
	localparam logic [RW-1:0] R3 = RW'((2 ** K) / 3 + 1);
	localparam logic [RW-1:0] R4 = RW'((2 ** K) / 4 + 1);
	localparam logic [RW-1:0] R5 = RW'((2 ** K) / 5 + 1);
	localparam logic [RW-1:0] R6 = RW'((2 ** K) / 6 + 1);
	localparam logic [RW-1:0] R7 = RW'((2 ** K) / 7 + 1);
	localparam logic [RW-1:0] R8 = RW'((2 ** K) / 8 + 1);
	localparam logic [RW-1:0] R9 = RW'((2 ** K) / 9 + 1);

	logic [RW-1:0]         recip;
	logic [PROD_W-1:0]     prod;
	logic                  valid_q;
	logic [PIXEL_BITS-1:0] mean_q;
	logic                  last_q;

	// a count of zero maps to zero, which yields a mean of zero
	always_comb begin
		unique case (cnt)
			CNT_W'(1): recip = R1;
			CNT_W'(2): recip = R2;
			CNT_W'(3): recip = R3;
			CNT_W'(4): recip = R4;
			CNT_W'(5): recip = R5;
			CNT_W'(6): recip = R6;
			CNT_W'(7): recip = R7;
			CNT_W'(8): recip = R8;
			CNT_W'(9): recip = R9;
			default:   recip = '0;
		endcase
		prod = PROD_W'(sum) * PROD_W'(recip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mean_q <= prod[K +: PIXEL_BITS];
			last_q <= fe;
		end
	end

	assign out_valid = valid_q;
	assign mean      = mean_q;
	assign last      = last_q;

endmodule

`default_nettype wire

>>> rtl/core/box_mean_3x3_clipped.sv
// top level of the 3x3 clipped box mean block
// uses bmc_pkg, bmc_ctrl, bmc_line_mem, bmc_window, bmc_div and the assertion macros
`default_nettype none

`include "box_mean_3x3_clipped_macros.svh"

// Streaming 3x3 box mean over a raster pixel stream, with the neighborhood clipped at the
// frame borders and an optional even-only or odd-only value filter. The block sustains one
// item per clock while the output is not stalled: each processed item does one read and
// one write of the two line stores, which share a single memory with a registered read,
// and the same-column case is bypassed. An item passes the window and sum stages before
// its result reaches the output register; output (r,c) is caused by the item at raster
// position (r+1)*width+c+1, so after the last pixel of a frame width+1 flush items push
// out the rest, the final one marked with tlast. Flush items inside a frame are taken and
// ignored. The input is held off in the cycle after every configuration write while the
// derived frame size settles. The line stores need no clearing after reset.
module box_mean_3x3_clipped #(
	parameter int MAX_WIDTH  = bmc_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = bmc_pkg::DEF_PIXEL_BITS,
	localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [TDATA_W-1:0]             s_tdata,   // pixel
	input  logic                           s_tuser,   // flush
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [TDATA_W-1:0]             m_tdata,   // mean
	output logic                           m_tlast
);

	import bmc_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int SUM_W = PIXEL_BITS + CNT_W;

	logic                    adv;
	logic                    act;
	logic [COL_W-1:0]        rd_addr;
	logic [PIXEL_BITS-1:0]   pix;
	ctl_t                    ctl;
	mode_t                   mode;
	logic [2*PIXEL_BITS-1:0] mem_rdata;
	logic                    mem_we;
	logic [COL_W-1:0]        mem_waddr;
	logic [2*PIXEL_BITS-1:0] mem_wdata;
	logic                    sum_valid;
	logic [SUM_W-1:0]        sum;
	logic [CNT_W-1:0]        cnt;
	logic                    sum_fe;
	logic [PIXEL_BITS-1:0]   mean;

	assign adv = !m_tvalid || m_tready;

	bmc_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.pixel     (s_tdata[PIXEL_BITS-1:0]),
		.flush     (s_tuser),
		.adv       (adv),
		.act       (act),
		.addr      (rd_addr),
		.pix       (pix),
		.ctl       (ctl),
		.mode      (mode)
	);

	bmc_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (2 * PIXEL_BITS)
	) u_line_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (act),
		.raddr (rd_addr),
		.rdata (mem_rdata)
	);

	bmc_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.act       (act),
		.addr      (rd_addr),
		.pix       (pix),
		.ctl       (ctl),
		.mode      (mode),
		.mem_rdata (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.out_valid (sum_valid),
		.out_sum   (sum),
		.out_cnt   (cnt),
		.out_fe    (sum_fe)
	);

	bmc_div #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sum_valid),
		.sum       (sum),
		.cnt       (cnt),
		.fe        (sum_fe),
		.out_valid (m_tvalid),
		.mean      (mean),
		.last      (m_tlast)
	);

	assign m_tdata = TDATA_W'(mean);

	`BMC_ASSERT_NXT(a_cfg_settle, clk, arst_n, cfg_we, !s_tready, "item taken while config settles")
	`BMC_ASSERT_IMP(a_ready_needs_room, clk, arst_n, s_tready, !m_tvalid || m_tready, "item taken while output stalled")
	`BMC_ASSERT_IMP(a_write_on_advance, clk, arst_n, mem_we, adv, "line store written during stall")

endmodule

`default_nettype wire
